>>> hdl/tu8c_pkg.sv
package tu8c_pkg;

	localparam int WORD_W       = 32;
	localparam int BYTE_W       = 8;
	localparam int MAX_CHANNELS = 4;
	localparam int CHANNELS     = 4;
	localparam int FMT_W        = 3;

	typedef enum logic [FMT_W-1:0] {
		FMT_BYTE  = 3'd0,
		FMT_UNORM = 3'd1,
		FMT_SNORM = 3'd2,
		FMT_HALF  = 3'd3,
		FMT_OTHER = 3'd4,
		FMT_FLOAT = 3'd5
	} fmt_t;

	// ceil(2^26 / 514): exact floor for numerators below 2^18
	localparam logic [16:0] UNORM_RECIP = 17'd130562;
	localparam int          UNORM_SHIFT = 26;
	// ceil(2^40 / 65534): exact floor for numerators below 2^24
	localparam logic [24:0] SNORM_RECIP = 25'd16777729;
	localparam int          SNORM_SHIFT = 40;

	// Round a shifted value: (y + 1) >> 1, clamped to one byte
	function automatic logic [BYTE_W-1:0] round_clamp(input logic [9:0] y);
		logic [10:0] r;
		r = ({1'b0, y} + 11'd1) >> 1;
		round_clamp = (r > 11'd255) ? 8'hFF : r[BYTE_W-1:0];
	endfunction

endpackage

>>> hdl/texel_to_unorm8_converter.sv
// Pixel format converter: four raw channel words in, four unorm8 bytes out.
// Input stream s_*: one request per pixel, s_tdata carries red, green, blue
// and alpha words of 32 bits each. Output stream m_*: one request per pixel,
// m_tdata carries the four converted bytes in the same order.
// cfg_wen/cfg_wdata load the source format register (byte copy, unorm16,
// snorm16, half float, other 16-bit, float32); write it only while idle.
// Each pixel passes an input register, then one pass through the channel
// converters (one small constant multiplier or shifter each) into the
// output register. Throughput is one pixel per cycle while m_tready stays high.
// Channels at or above CHANNELS are driven to zero.
// Reset clears both valid flags and sets the format to byte copy.
// When m_tready is low the output register holds its pixel and the input
// register keeps accepting until it is full; s_tready then drops in the
// same cycle and recovers as soon as the output request is taken.
module texel_to_unorm8_converter #(
	parameter int CHANNELS = tu8c_pkg::CHANNELS
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 s_tvalid,
	output logic                                                 s_tready,
	// red_word, green_word, blue_word, alpha_word
	input  logic [tu8c_pkg::MAX_CHANNELS*tu8c_pkg::WORD_W-1:0]   s_tdata,
	output logic                                                 m_tvalid,
	input  logic                                                 m_tready,
	// red_byte, green_byte, blue_byte, alpha_byte
	output logic [tu8c_pkg::MAX_CHANNELS*tu8c_pkg::BYTE_W-1:0]   m_tdata,
	input  logic                                                 cfg_wen,
	input  logic [tu8c_pkg::FMT_W-1:0]                           cfg_wdata
);

	localparam int IN_W  = tu8c_pkg::MAX_CHANNELS * tu8c_pkg::WORD_W;
	localparam int OUT_W = tu8c_pkg::MAX_CHANNELS * tu8c_pkg::BYTE_W;

	logic [tu8c_pkg::FMT_W-1:0] fmt_q;
	logic                       valid_s1;
	logic                       ready_s1;
	logic [IN_W-1:0]            data_s1;
	logic [OUT_W-1:0]           conv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= tu8c_pkg::FMT_BYTE;
		end else if (cfg_wen) begin
			fmt_q <= cfg_wdata;
		end
	end

	tu8c_pipe_reg #(
		.WIDTH (IN_W)
	) u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.out_valid (valid_s1),
		.out_ready (ready_s1),
		.out_data  (data_s1)
	);

	for (genvar c = 0; c < tu8c_pkg::MAX_CHANNELS; c++) begin : g_chan
		if (c < CHANNELS) begin : g_used
			tu8c_channel u_channel (
				.fmt    (fmt_q),
				.word   (data_s1[c*tu8c_pkg::WORD_W +: tu8c_pkg::WORD_W]),
				.result (conv_s1[c*tu8c_pkg::BYTE_W +: tu8c_pkg::BYTE_W])
			);
		end else begin : g_unused
			assign conv_s1[c*tu8c_pkg::BYTE_W +: tu8c_pkg::BYTE_W] = '0;
		end
	end

	tu8c_pipe_reg #(
		.WIDTH (OUT_W)
	) u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (ready_s1),
		.in_data   (conv_s1),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

>>> hdl/tu8c_channel.sv
module tu8c_channel (
	input  logic [tu8c_pkg::FMT_W-1:0]  fmt,
	input  logic [tu8c_pkg::WORD_W-1:0] word,
	output logic [tu8c_pkg::BYTE_W-1:0] result
);

	logic [15:0] v16;

	// unorm16: floor((2v + 257) / 514)
	logic [17:0] n_u;
	logic [34:0] prod_u;
	logic [7:0]  q_u;

	// snorm16: floor((255t + 32767) / 65534)
	logic [15:0] t_s;
	logic [24:0] n_s;
	logic [49:0] prod_s;
	logic [7:0]  q_s;

	// half float
	logic        h_sign;
	logic [4:0]  h_ex;
	logic [9:0]  h_man;
	logic [10:0] h_mag;
	logic [18:0] h_x;
	logic [4:0]  h_sa;
	logic [18:0] h_y;
	logic [7:0]  q_h;

	// single float
	logic        f_sign;
	logic [7:0]  f_ex;
	logic [22:0] f_man;
	logic [23:0] f_mag;
	logic [31:0] f_x;
	logic [7:0]  f_sa_full;
	logic [5:0]  f_sa;
	logic [31:0] f_y;
	logic [7:0]  q_f;

	assign v16 = word[15:0];

	assign n_u    = {1'b0, v16, 1'b0} + 18'd257;
	assign prod_u = {17'd0, n_u} * {18'd0, tu8c_pkg::UNORM_RECIP};
	assign q_u    = prod_u[tu8c_pkg::UNORM_SHIFT +: 8];

	always_comb begin
		if (v16 == 16'h8000) begin
			t_s = 16'd0;
		end else if (v16[15]) begin
			t_s = v16 - 16'h8001;
		end else begin
			t_s = v16 + 16'd32767;
		end
	end

	assign n_s    = {1'b0, t_s, 8'd0} - {9'd0, t_s} + 25'd32767;
	assign prod_s = {25'd0, n_s} * {25'd0, tu8c_pkg::SNORM_RECIP};
	assign q_s    = prod_s[tu8c_pkg::SNORM_SHIFT +: 8];

	assign h_sign = v16[15];
	assign h_ex   = v16[14:10];
	assign h_man  = v16[9:0];
	assign h_mag  = {(h_ex != 5'd0), h_man};
	assign h_x    = {h_mag, 8'd0} - {8'd0, h_mag};
	// shift by one less than the scale exponent, round on the last bit
	assign h_sa   = (h_ex == 5'd0) ? 5'd23 : (5'd24 - h_ex);
	assign h_y    = h_x >> h_sa;

	always_comb begin
		if (h_ex == 5'h1F) begin
			q_h = (h_man != 10'd0 || h_sign) ? 8'h00 : 8'hFF;
		end else if (h_sign) begin
			q_h = 8'h00;
		end else if (h_ex >= 5'd15) begin
			q_h = 8'hFF;
		end else begin
			q_h = tu8c_pkg::round_clamp(h_y[9:0]);
		end
	end

	assign f_sign    = word[31];
	assign f_ex      = word[30:23];
	assign f_man     = word[22:0];
	assign f_mag     = {(f_ex != 8'd0), f_man};
	assign f_x       = {f_mag, 8'd0} - {8'd0, f_mag};
	assign f_sa_full = 8'd149 - f_ex;
	assign f_sa      = f_sa_full[5:0];
	assign f_y       = f_x >> f_sa;

	always_comb begin
		if (f_ex == 8'hFF) begin
			q_f = (f_man != 23'd0 || f_sign) ? 8'h00 : 8'hFF;
		end else if (f_sign) begin
			q_f = 8'h00;
		end else if (f_ex >= 8'd127) begin
			q_f = 8'hFF;
		end else if (f_ex < 8'd117) begin
			// below 2^-10 the scaled value rounds to zero
			q_f = 8'h00;
		end else begin
			q_f = tu8c_pkg::round_clamp(f_y[9:0]);
		end
	end

	always_comb begin
		case (fmt)
			tu8c_pkg::FMT_BYTE:  result = word[7:0];
			tu8c_pkg::FMT_UNORM: result = q_u;
			tu8c_pkg::FMT_SNORM: result = q_s;
			tu8c_pkg::FMT_HALF:  result = q_h;
			tu8c_pkg::FMT_OTHER: result = 8'h00;
			tu8c_pkg::FMT_FLOAT: result = q_f;
			default:             result = 8'h00;
		endcase
	end

endmodule

>>> hdl/tu8c_pipe_reg.sv
module tu8c_pipe_reg #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic             valid_q;
	logic [WIDTH-1:0] data_q;

	// take a new request when empty or whenever the held one leaves in the same cycle
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= in_data;
		end
	end

endmodule
